@@ rtl/mpss_pkg.sv @@
// ----------------------------------------------------------------------------
// mpss_pkg
// types and constants shared by the m-psk phase sector slicer
// ----------------------------------------------------------------------------
package mpss_pkg;

	localparam int unsigned XY_W      = 64;
	localparam int unsigned ANGLE_W   = 32;
	localparam int unsigned SYMBOL_W  = 6;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned MAX_STAGE = 32;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd64;
	localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;
	localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [ANGLE_W-1:0] ATAN_TURNS [MAX_STAGE] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic                    valid;
		logic                    zero;
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic [ANGLE_W-1:0]      acc;
	} cordic_t;

endpackage

@@ rtl/mpss_if.sv @@
// ----------------------------------------------------------------------------
// mpss_if
// valid/ready channels for samples and decisions
// ----------------------------------------------------------------------------
interface mpss_sample_if #(
	parameter int unsigned SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] in_phase;
	logic signed [SAMPLE_WIDTH-1:0] quadrature;

	modport source (output valid, in_phase, quadrature, input ready);
	modport sink   (input valid, in_phase, quadrature, output ready);
endinterface

interface mpss_result_if #(
	parameter int unsigned PHASE_BITS = 16
);
	logic                            valid;
	logic                            ready;
	logic [PHASE_BITS-1:0]           phase_turns;
	logic [mpss_pkg::SYMBOL_W-1:0]   symbol;

	modport source (output valid, phase_turns, symbol, input ready);
	modport sink   (input valid, phase_turns, symbol, output ready);
endinterface

@@ rtl/mpss_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// mpss_cordic_stage
// one registered vectoring cordic iteration
// ----------------------------------------------------------------------------
module mpss_cordic_stage #(
	parameter int unsigned STAGE = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  mpss_pkg::cordic_t d,
	output mpss_pkg::cordic_t q
);

	logic                           valid_s1;
	mpss_pkg::cordic_t              data_s1;
	mpss_pkg::cordic_t              nxt;
	logic signed [mpss_pkg::XY_W-1:0] dx;
	logic signed [mpss_pkg::XY_W-1:0] dy;

	always_comb begin
		dx        = d.y >>> STAGE;
		dy        = d.x >>> STAGE;
		nxt       = d;
		if (!d.y[mpss_pkg::XY_W-1]) begin
			nxt.x   = d.x + dx;
			nxt.y   = d.y - dy;
			nxt.acc = d.acc + mpss_pkg::ATAN_TURNS[STAGE];
		end else begin
			nxt.x   = d.x - dx;
			nxt.y   = d.y + dy;
			nxt.acc = d.acc - mpss_pkg::ATAN_TURNS[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	always_comb begin
		q       = data_s1;
		q.valid = valid_s1;
	end

endmodule

@@ rtl/mpss_slicer.sv @@
// ----------------------------------------------------------------------------
// mpss_slicer
// rounds the angle to phase_turns and decides the sector, three stages
// ----------------------------------------------------------------------------
module mpss_slicer #(
	parameter int unsigned PHASE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic [mpss_pkg::COUNT_W-1:0]    phase_count,
	input  mpss_pkg::cordic_t               d,
	output logic                            valid,
	output logic [PHASE_BITS-1:0]           phase_turns,
	output logic [mpss_pkg::SYMBOL_W-1:0]   symbol
);

	localparam int unsigned SHIFT = mpss_pkg::ANGLE_W - PHASE_BITS;
	localparam int unsigned T_W   = PHASE_BITS + 8;
	localparam int unsigned S_W   = PHASE_BITS + 9;
	localparam logic [mpss_pkg::ANGLE_W:0] HALF_LSB =
		(SHIFT > 0) ? ((mpss_pkg::ANGLE_W+1)'(1) << (SHIFT - 1)) : '0;
	localparam logic [S_W-1:0] UNIT = S_W'(1) << PHASE_BITS;

	logic [mpss_pkg::ANGLE_W:0]   rsum;
	logic [mpss_pkg::COUNT_W-1:0] m_c;
	logic [S_W-1:0]               t_ext;
	logic [S_W-1:0]               ksum;
	logic [7:0]                   k;
	logic [mpss_pkg::SYMBOL_W-1:0] sym_c;

	logic                          valid_s1, valid_s2, valid_s3;
	logic [PHASE_BITS-1:0]         phase_s1, phase_s2, phase_s3;
	logic [T_W-1:0]                t_s2;
	logic [mpss_pkg::COUNT_W-1:0]  m_s2;
	logic                          low_s2;
	logic [mpss_pkg::SYMBOL_W-1:0] sym_s3;

	// round half up and wrap
	assign rsum = {1'b0, d.acc} + HALF_LSB;

	always_comb begin
		m_c   = (phase_count > mpss_pkg::COUNT_MAX) ? mpss_pkg::COUNT_MAX : phase_count;
		t_ext = {1'b0, t_s2};
		ksum  = t_ext + UNIT - S_W'(1);
		k     = ksum[S_W-1 -: 8];
		sym_c = k[mpss_pkg::SYMBOL_W-1:0];
		if (low_s2 || (t_ext <= UNIT) || (k >= {1'b0, m_s2})) begin
			sym_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= d.zero ? '0 : rsum[SHIFT +: PHASE_BITS];
			phase_s2 <= phase_s1;
			t_s2     <= T_W'(phase_s1) * T_W'({m_c, 1'b0});
			m_s2     <= m_c;
			low_s2   <= (m_c < mpss_pkg::COUNT_MIN);
			phase_s3 <= phase_s2;
			sym_s3   <= sym_c;
		end
	end

	assign valid       = valid_s3;
	assign phase_turns = phase_s3;
	assign symbol      = sym_s3;

endmodule

@@ rtl/mpsk_phase_sector_slicer_core.sv @@
// ----------------------------------------------------------------------------
// mpsk_phase_sector_slicer_core
// m-psk hard decision: cordic atan2 phase and sector index per i/q sample
//
//   channel  dir  handshake      payload
//   sample   in   valid/ready    in_phase, quadrature
//   result   out  valid/ready    phase_turns, symbol
//   cfg      in   cfg_we         cfg_wdata (phase_count)
//
// one beat per cycle sustained while the result channel is not stalled
// one input stage, one stage per cordic iteration, three slicer stages
// a stalled result holds the whole pipeline; sample.ready follows it
// arst_n clears the valid bits and sets phase_count to 4
// ----------------------------------------------------------------------------
module mpsk_phase_sector_slicer_core #(
	parameter int unsigned SAMPLE_WIDTH  = 16,
	parameter int unsigned PHASE_BITS    = 16,
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mpss_pkg::COUNT_W-1:0]  cfg_wdata,
	mpss_sample_if.sink                   sample,
	mpss_result_if.source                 result
);

	localparam int unsigned SCALE = 62 - SAMPLE_WIDTH;
	localparam int unsigned EXT   = mpss_pkg::XY_W - SAMPLE_WIDTH;

	logic                          en;
	logic [mpss_pkg::COUNT_W-1:0]  phase_count_q;
	logic signed [mpss_pkg::XY_W-1:0] xs;
	logic signed [mpss_pkg::XY_W-1:0] ys;
	mpss_pkg::cordic_t             pre_c;
	mpss_pkg::cordic_t             pre_s1;
	logic                          valid_s1;
	mpss_pkg::cordic_t             chain [CORDIC_STAGES+1];

	assign en           = !result.valid || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_count_q <= mpss_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			phase_count_q <= cfg_wdata;
		end
	end

	// scale and fold the left half plane
	always_comb begin
		xs          = {{EXT{sample.in_phase[SAMPLE_WIDTH-1]}}, sample.in_phase} <<< SCALE;
		ys          = {{EXT{sample.quadrature[SAMPLE_WIDTH-1]}}, sample.quadrature} <<< SCALE;
		pre_c.valid = sample.valid;
		pre_c.zero  = (sample.in_phase == '0) && (sample.quadrature == '0);
		pre_c.x     = xs;
		pre_c.y     = ys;
		pre_c.acc   = '0;
		if (xs[mpss_pkg::XY_W-1]) begin
			pre_c.x   = -xs;
			pre_c.y   = -ys;
			pre_c.acc = mpss_pkg::HALF_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pre_c;
		end
	end

	assign chain[0] = '{
		valid: valid_s1,
		zero:  pre_s1.zero,
		x:     pre_s1.x,
		y:     pre_s1.y,
		acc:   pre_s1.acc
	};

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		mpss_cordic_stage #(
			.STAGE (g)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	mpss_slicer #(
		.PHASE_BITS (PHASE_BITS)
	) u_slicer (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.phase_count (phase_count_q),
		.d           (chain[CORDIC_STAGES]),
		.valid       (result.valid),
		.phase_turns (result.phase_turns),
		.symbol      (result.symbol)
	);

endmodule

@@ tb/sv/tb_mpsk_phase_sector_slicer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mpsk_phase_sector_slicer_core
// self-checking bench for the m-psk phase sector slicer
//
// drives i/q samples through the valid/ready sample channel and checks every
// result beat against a bit-true cordic atan2 and sector decision computed in
// the bench. phase counts from zero up to the 7-bit maximum are loaded between
// phases; directed points cover the axes, the corners, the zero sample and
// the negative real axis, and random points add full-range values, small
// vectors and vectors close to sector edges. both channels idle at random,
// and the receiver holds off once long enough to back the pipeline up.
// ----------------------------------------------------------------------------

typedef struct {
	logic [15:0] phase_turns;
	logic [5:0]  symbol;
} decision_t;

class decision_ledger;
	localparam int STAGES = 16;

	logic [mpss_pkg::COUNT_W-1:0] phase_count = mpss_pkg::COUNT_RESET;
	decision_t                    expected_decisions[$];
	int unsigned                  errors = 0;

	function automatic decision_t predict_decision(logic signed [15:0] i_s,
			logic signed [15:0] q_s);
		logic signed [63:0] x, y, dx, dy;
		logic [31:0]        angle;
		logic [63:0]        rounded, t, k, m;
		decision_t          d;
		d.phase_turns = '0;
		d.symbol      = '0;
		if (i_s == 0 && q_s == 0) begin
			return d;
		end
		x = 64'(i_s);
		y = 64'(q_s);
		x = x <<< 46;
		y = y <<< 46;
		angle = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			angle = mpss_pkg::HALF_TURN;
		end
		for (int s = 0; s < STAGES; s++) begin
			dx = y >>> s;
			dy = x >>> s;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				angle = angle + mpss_pkg::ATAN_TURNS[s];
			end else begin
				x = x - dx;
				y = y + dy;
				angle = angle - mpss_pkg::ATAN_TURNS[s];
			end
		end
		rounded = ({32'd0, angle} + 64'd32768) >> 16;
		d.phase_turns = rounded[15:0];
		m = {57'd0, phase_count};
		if (m > 64) begin
			m = 64'd64;
		end
		if (m < 2) begin
			return d;
		end
		t = {48'd0, d.phase_turns} * 64'd2 * m;
		if (t <= 64'd65536) begin
			return d;
		end
		k = (t + 64'd65535) >> 17;
		if (k < m) begin
			d.symbol = k[5:0];
		end
		return d;
	endfunction

	function void note_sample(logic signed [15:0] i_s, logic signed [15:0] q_s);
		expected_decisions.push_back(predict_decision(i_s, q_s));
	endfunction

	function void check_decision(logic [15:0] phase_turns, logic [5:0] symbol);
		decision_t d;
		if (expected_decisions.size() == 0) begin
			$display("%0t: unexpected result beat phase_turns %0d symbol %0d",
				$time, phase_turns, symbol);
			errors++;
			return;
		end
		d = expected_decisions.pop_front();
		if (phase_turns !== d.phase_turns) begin
			$display("%0t: phase_turns expected %0d actual %0d",
				$time, d.phase_turns, phase_turns);
			errors++;
		end
		if (symbol !== d.symbol) begin
			$display("%0t: symbol expected %0d actual %0d (phase_count %0d)",
				$time, d.symbol, symbol, phase_count);
			errors++;
		end
	endfunction

	function int pending();
		return expected_decisions.size();
	endfunction
endclass

module tb_mpsk_phase_sector_slicer_core;

	localparam int          LATENCY     = 16 + 4;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          CHUNKS      = 10;
	localparam int          CHUNK_ITEMS = 80;
	localparam real         TWO_PI      = 6.283185307179586;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [mpss_pkg::COUNT_W-1:0]  cfg_wdata;
	int                            src_idle;
	int                            snk_idle;
	int                            hold_cycles;
	int unsigned                   cycle_count;

	decision_ledger ledger = new();

	mpss_sample_if #(.SAMPLE_WIDTH(16)) smp ();
	mpss_result_if #(.PHASE_BITS(16))   res ();

	mpsk_phase_sector_slicer_core #(
		.SAMPLE_WIDTH (16),
		.PHASE_BITS   (16),
		.CORDIC_STAGES(16)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample   (smp),
		.result   (res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (smp.valid && smp.ready) begin
				ledger.note_sample(smp.in_phase, smp.quadrature);
			end
			if (res.valid && res.ready) begin
				ledger.check_decision(res.phase_turns, res.symbol);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: random back-pressure, or a counted hold-off when requested
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res.ready = 1'b0;
				hold_cycles--;
			end else begin
				res.ready = (snk_idle == 0) || ($urandom_range(99) >= snk_idle);
			end
		end
	end

	task automatic put_sample(logic signed [15:0] i_s, logic signed [15:0] q_s);
		while (src_idle != 0 && $urandom_range(99) < src_idle) begin
			smp.valid = 1'b0;
			@(negedge clk);
		end
		smp.valid      = 1'b1;
		smp.in_phase   = i_s;
		smp.quadrature = q_s;
		do @(posedge clk); while (!smp.ready);
		@(negedge clk);
	endtask

	task automatic load_phase_count(logic [mpss_pkg::COUNT_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		ledger.phase_count = value;
	endtask

	task automatic drain();
		while (ledger.pending() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic pick_sample(int unsigned count, output logic signed [15:0] i_s,
			output logic signed [15:0] q_s);
		int          sel, mm, j;
		real         ang, r;
		int          edges[5];
		edges = '{-32768, -1, 0, 1, 32767};
		sel = $urandom_range(99);
		if (sel < 60) begin
			i_s = 16'($urandom);
			q_s = 16'($urandom);
		end else if (sel < 75) begin
			i_s = 16'(int'($urandom_range(15)) - 8);
			q_s = 16'(int'($urandom_range(15)) - 8);
		end else if (sel < 90) begin
			// close to a sector edge
			mm = (count < 2) ? 2 : (count > 64) ? 64 : count;
			j = $urandom_range(2 * mm - 1);
			ang = TWO_PI * j / (2.0 * mm) + (real'($urandom_range(200)) - 100.0) * 1.0e-5;
			r = real'($urandom_range(32767, 1000));
			i_s = 16'($rtoi(r * $cos(ang)));
			q_s = 16'($rtoi(r * $sin(ang)));
		end else begin
			i_s = 16'(edges[$urandom_range(4)]);
			q_s = 16'(edges[$urandom_range(4)]);
		end
	endtask

	initial begin
		logic [31:0]                  directed[$];
		logic [mpss_pkg::COUNT_W-1:0] counts[CHUNKS];
		logic signed [15:0]           i_s, q_s;
		directed = '{
			{16'sd0, 16'sd0},          {16'sd32767, 16'sd0},
			{-16'sd32768, 16'sd0},     {-16'sd1, 16'sd0},
			{-16'sd32768, 16'sd1},     {-16'sd32768, -16'sd1},
			{16'sd0, 16'sd32767},      {16'sd0, -16'sd32768},
			{16'sd32767, 16'sd32767},  {-16'sd32768, -16'sd32768},
			{-16'sd32768, 16'sd32767}, {16'sd32767, -16'sd32768},
			{16'sd1, 16'sd0},          {16'sd0, 16'sd1},
			{16'sd0, -16'sd1},         {-16'sd1, -16'sd1},
			{16'sd1, -16'sd1},         {16'sd1, 16'sd1},
			{16'sd32767, 16'sd1},      {16'sd32767, -16'sd1},
			{16'sd12345, 16'sd12345},  {-16'sd20000, 16'sd20000}
		};
		counts = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd3, 7'd65, 7'd127, 7'd8, 7'd5, 7'd16};
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		smp.valid      = 1'b0;
		smp.in_phase   = '0;
		smp.quadrature = '0;
		src_idle       = 10;
		snk_idle       = 79;
		hold_cycles    = 0;
		cycle_count    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset phase count of four
		foreach (directed[n]) begin
			put_sample(directed[n][31:16], directed[n][15:0]);
		end
		smp.valid = 1'b0;
		drain();

		for (int c = 0; c < CHUNKS; c++) begin
			if (c == 3) begin
				src_idle = 79;
				snk_idle = 10;
			end else if (c == 6) begin
				src_idle = 0;
				snk_idle = 0;
			end
			load_phase_count(counts[c]);
			if (c == 6) begin
				hold_cycles = 200;
			end
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				pick_sample(counts[c], i_s, q_s);
				put_sample(i_s, q_s);
			end
			smp.valid = 1'b0;
			drain();
		end

		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (ledger.pending() != 0) begin
				$display("%0t: %0d expected results never arrived", $time, ledger.pending());
			end
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mpss_pkg.sv
rtl/mpss_if.sv
rtl/mpss_cordic_stage.sv
rtl/mpss_slicer.sv
rtl/mpsk_phase_sector_slicer_core.sv
tb/sv/tb_mpsk_phase_sector_slicer_core.sv
